### hdl/cvcd_pkg.sv
// ----------------------------------------------------------------------------
// cvcd_pkg
// Shared field widths, request codes, address windows and the fetch delay
// table of the video contention delay pipeline.
// ----------------------------------------------------------------------------
package cvcd_pkg;

  localparam int TSTATE_W = 17;
  localparam int ADDR_W   = 16;
  localparam int WAIT_W   = 5;
  localparam int CHK_W    = 3;

  localparam logic [TSTATE_W-1:0] TSTATE_MAX = '1;
  localparam logic [WAIT_W-1:0]   WAIT_MAX   = 5'd24;

  // Request kinds.
  localparam logic REQ_MEM = 1'b0;
  localparam logic REQ_IO  = 1'b1;

  // Contended memory window and contended port high byte window.
  localparam logic [ADDR_W-1:0] MEM_LO     = 16'h4000;
  localparam logic [ADDR_W-1:0] MEM_HI     = 16'h7FFF;
  localparam logic [7:0]        PORT_HI_LO = 8'h40;
  localparam logic [7:0]        PORT_HI_HI = 8'h7F;

  // Number of check points an access walks through.
  localparam logic [CHK_W-1:0] CHK_NONE = 3'd0;
  localparam logic [CHK_W-1:0] CHK_ONE  = 3'd1;
  localparam logic [CHK_W-1:0] CHK_TWO  = 3'd2;
  localparam logic [CHK_W-1:0] CHK_FOUR = 3'd4;

  // Work that still travels with a request through the check stages.
  typedef struct packed {
    logic [CHK_W-1:0]    checks;
    logic [WAIT_W-1:0]   waits;
    logic [TSTATE_W-1:0] tstate;
  } chk_t;

  // Wait added by the video fetch at a given position of an eight T-state group.
  function automatic logic [2:0] fetch_wait(input logic [2:0] pos);
    logic [2:0] w;
    unique case (pos)
      3'd0:    w = 3'd6;
      3'd1:    w = 3'd5;
      3'd2:    w = 3'd4;
      3'd3:    w = 3'd3;
      3'd4:    w = 3'd2;
      3'd5:    w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

### hdl/cvcd_decode.sv
// ----------------------------------------------------------------------------
// cvcd_decode
// First pipeline stage: classifies the access, picks its check pattern and
// offsets the starting T-state against the first contended T-state.
// ----------------------------------------------------------------------------
module cvcd_decode import cvcd_pkg::*; #(
  parameter int FIRST_CONTENDED_TSTATE = 14335,
  parameter int RelW                   = 18,
  parameter int ColW                   = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       req_type_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic [TSTATE_W-1:0]        frame_tstate_i,
  output chk_t                       chk_o,
  output logic                       neg_o,
  output logic [RelW-1:0]            rel_o,
  output logic signed [ColW-1:0]     vneg_o
);

  localparam int DiffW = RelW + 1;

  logic                    hi_busy;
  logic                    mem_busy;
  logic [CHK_W-1:0]        checks;
  logic                    offset;
  logic [RelW-1:0]         t_start;
  logic [DiffW-1:0]        diff;

  chk_t                    chk_q;
  logic                    neg_q;
  logic [RelW-1:0]         rel_q;
  logic signed [ColW-1:0]  vneg_q;

  assign hi_busy  = (address_i[15:8] >= PORT_HI_LO) && (address_i[15:8] <= PORT_HI_HI);
  assign mem_busy = (address_i >= MEM_LO) && (address_i <= MEM_HI);

  // An even port outside the contended high byte range is checked one
  // T-state late; every other pattern starts at the request T-state.
  always_comb begin
    offset = 1'b0;
    checks = CHK_NONE;
    if (req_type_i == REQ_MEM) begin
      checks = mem_busy ? CHK_ONE : CHK_NONE;
    end else if (!address_i[0]) begin
      if (hi_busy) begin
        checks = CHK_TWO;
      end else begin
        checks = CHK_ONE;
        offset = 1'b1;
      end
    end else begin
      checks = hi_busy ? CHK_FOUR : CHK_NONE;
    end
  end

  assign t_start = RelW'(frame_tstate_i) + RelW'(offset);
  assign diff    = DiffW'(t_start) - DiffW'(FIRST_CONTENDED_TSTATE);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chk_q.checks <= checks;
      chk_q.waits  <= '0;
      chk_q.tstate <= frame_tstate_i;
      neg_q        <= diff[DiffW-1];
      rel_q        <= diff[RelW-1:0];
      vneg_q       <= $signed(diff[ColW-1:0]);
    end
  end

  assign chk_o  = chk_q;
  assign neg_o  = neg_q;
  assign rel_o  = rel_q;
  assign vneg_o = vneg_q;

endmodule

### hdl/cvcd_linepos.sv
// ----------------------------------------------------------------------------
// cvcd_linepos
// Two pipeline stages that split the offset T-state into display line and
// position within the line: a reciprocal multiply, then the remainder.
// ----------------------------------------------------------------------------
module cvcd_linepos import cvcd_pkg::*; #(
  parameter int TSTATES_PER_LINE = 224,
  parameter int RelW             = 18,
  parameter int ColW             = 16,
  parameter int RowW             = 12
) (
  input  logic                    clk_i,
  input  logic                    en1_i,
  input  logic                    en2_i,
  input  chk_t                    chk_i,
  input  logic                    neg_i,
  input  logic [RelW-1:0]         rel_i,
  input  logic signed [ColW-1:0]  vneg_i,
  output chk_t                    chk_o,
  output logic [RowW-1:0]         row_o,
  output logic signed [ColW-1:0]  col_o
);

  // Rounded-up reciprocal with enough fraction bits for an exact quotient
  // over the whole dividend range.
  localparam int RemW   = $clog2(TSTATES_PER_LINE);
  localparam int ShW    = RelW + RemW;
  localparam int RecipW = RelW + 1;
  localparam int ProdW  = RelW + RecipW;
  localparam longint unsigned Recip =
      ((64'd1 << ShW) + 64'(TSTATES_PER_LINE) - 64'd1) / 64'(TSTATES_PER_LINE);

  logic [ProdW-1:0]        prod;
  logic [ProdW-1:0]        quot_full;
  logic [RelW-1:0]         qp;
  logic [RelW-1:0]         rem;

  chk_t                    chk1_q;
  logic                    neg1_q;
  logic [RelW-1:0]         rel1_q;
  logic signed [ColW-1:0]  vneg1_q;
  logic [RowW-1:0]         quot1_q;

  chk_t                    chk2_q;
  logic [RowW-1:0]         row2_q;
  logic signed [ColW-1:0]  col2_q;

  assign prod      = ProdW'(rel_i) * ProdW'(RecipW'(Recip));
  assign quot_full = prod >> ShW;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      chk1_q  <= chk_i;
      neg1_q  <= neg_i;
      rel1_q  <= rel_i;
      vneg1_q <= vneg_i;
      quot1_q <= quot_full[RowW-1:0];
    end
  end

  assign qp  = RelW'(quot1_q * TSTATES_PER_LINE);
  assign rem = rel1_q - qp;

  // Before the first contended T-state the column carries the negative
  // distance, and the line count starts at zero.
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      chk2_q <= chk1_q;
      if (neg1_q) begin
        row2_q <= '0;
        col2_q <= vneg1_q;
      end else begin
        row2_q <= quot1_q;
        col2_q <= $signed(ColW'(rem[RemW-1:0]));
      end
    end
  end

  assign chk_o = chk2_q;
  assign row_o = row2_q;
  assign col_o = col2_q;

endmodule

### hdl/cvcd_step.sv
// ----------------------------------------------------------------------------
// cvcd_step
// One check point of the chain: looks up the fetch delay at the running
// position, adds it and moves the position on by that delay plus one.
// ----------------------------------------------------------------------------
module cvcd_step import cvcd_pkg::*; #(
  parameter int TSTATES_PER_LINE   = 224,
  parameter int CONTENDED_LINES    = 192,
  parameter int CONTENDED_PER_LINE = 128,
  parameter int ColW               = 16,
  parameter int RowW               = 12
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  chk_t                    chk_i,
  input  logic [RowW-1:0]         row_i,
  input  logic signed [ColW-1:0]  col_i,
  output chk_t                    chk_o,
  output logic [RowW-1:0]         row_o,
  output logic signed [ColW-1:0]  col_o
);

  logic                    active;
  logic                    in_window;
  logic [2:0]              delay;
  logic signed [ColW-1:0]  adv;
  logic signed [ColW-1:0]  col_nx;
  logic                    wrap;

  chk_t                    chk_q;
  logic [RowW-1:0]         row_q;
  logic signed [ColW-1:0]  col_q;

  assign active    = (chk_i.checks != CHK_NONE);
  assign in_window = !col_i[ColW-1]
                  && (col_i < $signed(ColW'(CONTENDED_PER_LINE)))
                  && (row_i < RowW'(CONTENDED_LINES));
  assign delay     = in_window ? fetch_wait(col_i[2:0]) : 3'd0;
  assign adv       = $signed(ColW'(delay) + ColW'(1));
  assign col_nx    = col_i + adv;
  assign wrap      = (col_nx >= $signed(ColW'(TSTATES_PER_LINE)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chk_q.tstate <= chk_i.tstate;
      if (active) begin
        chk_q.checks <= chk_i.checks - CHK_ONE;
        chk_q.waits  <= chk_i.waits + WAIT_W'(delay);
        if (wrap) begin
          col_q <= col_nx - $signed(ColW'(TSTATES_PER_LINE));
          row_q <= row_i + RowW'(1);
        end else begin
          col_q <= col_nx;
          row_q <= row_i;
        end
      end else begin
        chk_q.checks <= chk_i.checks;
        chk_q.waits  <= chk_i.waits;
        col_q        <= col_i;
        row_q        <= row_i;
      end
    end
  end

  assign chk_o = chk_q;
  assign row_o = row_q;
  assign col_o = col_q;

endmodule

### hdl/cpu_video_contention_delay.sv
// ----------------------------------------------------------------------------
// cpu_video_contention_delay
// Wait states that the video fetch adds to a CPU memory or I/O access, and
// the frame T-state after those waits.
// ----------------------------------------------------------------------------
// A request can be accepted in every cycle unless a full pipeline is held by a
// stalled result, so the block sustains one access per clock while results are
// taken. The eight register stages are: decode and offset against the first
// contended T-state, a reciprocal multiply that finds the display line, the
// remainder that gives the position within the line, four check point stages
// (one per possible check of the longest I/O pattern), and the output
// register with the saturating T-state add. Each stage holds its own valid
// bit and moves on whenever the stage after it is free, so a stalled result
// keeps only the stages behind it waiting and bubbles are filled up.
// ----------------------------------------------------------------------------
module cpu_video_contention_delay import cvcd_pkg::*; #(
  parameter int FIRST_CONTENDED_TSTATE = 14335,
  parameter int TSTATES_PER_LINE       = 224,
  parameter int CONTENDED_LINES        = 192,
  parameter int CONTENDED_PER_LINE     = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [TSTATE_W-1:0] frame_tstate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WAIT_W-1:0]   wait_states_o,
  output logic [TSTATE_W-1:0] adjusted_tstate_o
);

  // The even-port offset can move the start one T-state past the end of the
  // field range, so offsets against the first contended T-state take one
  // extra bit. The column holds the position in a line, or the negative
  // distance to the first contended T-state before it.
  localparam int RelW    = TSTATE_W + 1;
  localparam int ColSpan = (FIRST_CONTENDED_TSTATE > TSTATES_PER_LINE + 8)
                         ? FIRST_CONTENDED_TSTATE : TSTATES_PER_LINE + 8;
  localparam int ColW    = $clog2(ColSpan + 1) + 1;
  localparam int RowW    = RelW - $clog2(TSTATES_PER_LINE + 1) + 2;
  localparam int NStg    = 8;
  localparam int NChk    = 4;
  localparam int StgStep = 3;
  localparam int StgOut  = NStg - 1;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  chk_t                    chk_dec;
  logic                    neg_dec;
  logic [RelW-1:0]         rel_dec;
  logic signed [ColW-1:0]  vneg_dec;

  chk_t                    chk_s [NChk+1];
  logic [RowW-1:0]         row_s [NChk+1];
  logic signed [ColW-1:0]  col_s [NChk+1];

  logic [TSTATE_W:0]       sum;
  logic [WAIT_W-1:0]       wait_q;
  logic [TSTATE_W-1:0]     adj_q;

  // A stage may load when it is empty or when its own request moves on.
  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  cvcd_decode #(
    .FIRST_CONTENDED_TSTATE(FIRST_CONTENDED_TSTATE),
    .RelW                  (RelW),
    .ColW                  (ColW)
  ) u_decode (
    .clk_i         (clk_i),
    .en_i          (en[0]),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .frame_tstate_i(frame_tstate_i),
    .chk_o         (chk_dec),
    .neg_o         (neg_dec),
    .rel_o         (rel_dec),
    .vneg_o        (vneg_dec)
  );

  cvcd_linepos #(
    .TSTATES_PER_LINE(TSTATES_PER_LINE),
    .RelW            (RelW),
    .ColW            (ColW),
    .RowW            (RowW)
  ) u_linepos (
    .clk_i (clk_i),
    .en1_i (en[1]),
    .en2_i (en[2]),
    .chk_i (chk_dec),
    .neg_i (neg_dec),
    .rel_i (rel_dec),
    .vneg_i(vneg_dec),
    .chk_o (chk_s[0]),
    .row_o (row_s[0]),
    .col_o (col_s[0])
  );

  // Each check stage handles one check point while checks remain, and
  // passes the request through untouched once they are used up.
  for (genvar g = 0; g < NChk; g++) begin : g_step
    cvcd_step #(
      .TSTATES_PER_LINE  (TSTATES_PER_LINE),
      .CONTENDED_LINES   (CONTENDED_LINES),
      .CONTENDED_PER_LINE(CONTENDED_PER_LINE),
      .ColW              (ColW),
      .RowW              (RowW)
    ) u_step (
      .clk_i(clk_i),
      .en_i (en[StgStep+g]),
      .chk_i(chk_s[g]),
      .row_i(row_s[g]),
      .col_i(col_s[g]),
      .chk_o(chk_s[g+1]),
      .row_o(row_s[g+1]),
      .col_o(col_s[g+1])
    );
  end

  // The reported wait count is never clipped; only the T-state saturates.
  assign sum = (TSTATE_W+1)'(chk_s[NChk].tstate) + (TSTATE_W+1)'(chk_s[NChk].waits);

  always_ff @(posedge clk_i) begin
    if (en[StgOut]) begin
      wait_q <= chk_s[NChk].waits;
      adj_q  <= sum[TSTATE_W] ? TSTATE_MAX : sum[TSTATE_W-1:0];
    end
  end

  assign out_valid_o       = vld_q[StgOut];
  assign wait_states_o     = wait_q;
  assign adjusted_tstate_o = adj_q;

  // The pipeline never refuses a request while some stage is empty.
  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> in_ready_o)
    else $error("request refused with an empty pipeline stage");

  // Four check stages are enough for the longest pattern.
  a_checks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StgOut-1] |-> (chk_s[NChk].checks == CHK_NONE))
    else $error("check points left after the last check stage");

  // The wait total stays inside its documented range.
  a_wait_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wait_states_o <= WAIT_MAX))
    else $error("wait states out of range");

  // The adjusted T-state is never below the request T-state plus the waits,
  // unless it has saturated.
  a_adj_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[StgOut-1] && en[StgOut]) |=>
      ((adjusted_tstate_o == TSTATE_MAX) || ({1'b0, adjusted_tstate_o} == $past(sum))))
    else $error("adjusted T-state does not match the wait count");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the video contention delay pipeline: CPU memory and
// I/O requests go in with random gaps, and every result is compared with an
// independent model of the contention wait patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cvcd_pkg::*;

  // Frame timing of the block, passed to the instance as well.
  localparam int unsigned FIRST_CONTENDED = 14335;
  localparam int unsigned LINE_LEN        = 224;
  localparam int unsigned CONTENDED_ROWS  = 192;
  localparam int unsigned ACTIVE_LEN      = 128;
  localparam int unsigned LAST_CONTENDED  = FIRST_CONTENDED + CONTENDED_ROWS * LINE_LEN;

  // Eight pipeline stages plus some slack before the pipeline counts as empty.
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 285;

  typedef struct {
    logic [WAIT_W-1:0]   waits;
    logic [TSTATE_W-1:0] tstate;
  } timing_t;

  // Holds the timing expected for every accepted request, oldest first, and
  // computes it from the contention rules of the video fetch.
  class contention_checker;
    timing_t pending_timing[$];
    int      errors = 0;

    // Delay that the video fetch adds at T-state t. Positions 0..5 of each
    // group of eight cost 6..1 waits, the last two cost nothing.
    function int unsigned fetch_delay(int unsigned t);
      int unsigned rel;
      int unsigned row;
      int unsigned col;
      if (t < FIRST_CONTENDED) return 0;
      rel = t - FIRST_CONTENDED;
      row = rel / LINE_LEN;
      if (row >= CONTENDED_ROWS) return 0;
      col = rel % LINE_LEN;
      if (col >= ACTIVE_LEN) return 0;
      return ((col % 8) < 6) ? 6 - (col % 8) : 0;
    endfunction

    // Waits for an I/O request. The running T-state is kept at 32 bits, so
    // check points past the end of the field still see their true position.
    function int unsigned port_waits(logic [ADDR_W-1:0] port, int unsigned t);
      int unsigned total;
      int unsigned d;
      bit          hi_busy;
      total   = 0;
      hi_busy = (port[15:8] >= PORT_HI_LO) && (port[15:8] <= PORT_HI_HI);
      if (!port[0]) begin
        if (hi_busy) begin
          d     = fetch_delay(t);
          total = d;
          t     = t + d + 1;
          total = total + fetch_delay(t);
        end else begin
          total = fetch_delay(t + 1);
        end
      end else if (hi_busy) begin
        repeat (4) begin
          d     = fetch_delay(t);
          total = total + d;
          t     = t + d + 1;
        end
      end
      return total;
    endfunction

    function void note_request(logic kind, logic [ADDR_W-1:0] addr,
                               logic [TSTATE_W-1:0] t);
      timing_t     exp;
      int unsigned waits;
      int unsigned sum;
      if (kind == REQ_MEM)
        waits = (addr >= MEM_LO && addr <= MEM_HI) ? fetch_delay(32'(t)) : 0;
      else
        waits = port_waits(addr, 32'(t));
      sum = t + waits;
      if (sum > TSTATE_MAX) sum = 32'(TSTATE_MAX);
      exp.waits  = waits[WAIT_W-1:0];
      exp.tstate = sum[TSTATE_W-1:0];
      pending_timing.push_back(exp);
    endfunction

    function void check_result(logic [WAIT_W-1:0] waits, logic [TSTATE_W-1:0] tstate);
      timing_t exp;
      if (pending_timing.size() == 0) begin
        $error("unexpected result: wait_states %0d adjusted_tstate %0d", waits, tstate);
        errors++;
        return;
      end
      exp = pending_timing.pop_front();
      if (waits !== exp.waits) begin
        $error("wait_states: expected %0d, got %0d", exp.waits, waits);
        errors++;
      end
      if (tstate !== exp.tstate) begin
        $error("adjusted_tstate: expected %0d, got %0d", exp.tstate, tstate);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic                req_type_i        = REQ_MEM;
  logic [ADDR_W-1:0]   address_i         = '0;
  logic [TSTATE_W-1:0] frame_tstate_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic [WAIT_W-1:0]   wait_states_o;
  logic [TSTATE_W-1:0] adjusted_tstate_o;

  contention_checker timing_check = new();
  int                send_idle_pct = 13;
  int                recv_idle_pct = 60;
  int                cycle_count   = 0;

  cpu_video_contention_delay #(
    .FIRST_CONTENDED_TSTATE(FIRST_CONTENDED),
    .TSTATES_PER_LINE      (LINE_LEN),
    .CONTENDED_LINES       (CONTENDED_ROWS),
    .CONTENDED_PER_LINE    (ACTIVE_LEN)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .frame_tstate_i   (frame_tstate_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .wait_states_o    (wait_states_o),
    .adjusted_tstate_o(adjusted_tstate_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side. Values are read right after the edge, before any update of
  // that edge lands, so they are the ones the handshake saw. Ready is then
  // redrawn for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      timing_check.check_result(wait_states_o, adjusted_tstate_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one request, after a random number of idle cycles, and holds it
  // until the block takes it. Valid stays high afterwards so that back to back
  // requests need no bubble.
  task automatic send_request(logic kind, logic [ADDR_W-1:0] addr,
                              logic [TSTATE_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    address_i      <= addr;
    frame_tstate_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    timing_check.note_request(kind, addr, t);
  endtask

  // Stops sending until every outstanding request has returned its result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (timing_check.pending_timing.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Frame T-states weighted toward the contended display area, its edges and
  // the top of the field, with a share drawn over the whole field.
  function automatic logic [TSTATE_W-1:0] pick_tstate();
    int unsigned sel;
    sel = $urandom_range(9);
    unique case (sel)
      0, 1, 2, 3, 4, 5: begin
        return TSTATE_W'(FIRST_CONTENDED + $urandom_range(CONTENDED_ROWS * LINE_LEN - 1));
      end
      6: begin
        return TSTATE_W'(FIRST_CONTENDED - 8 + $urandom_range(40));
      end
      7: begin
        return TSTATE_W'(LAST_CONTENDED - 40 + $urandom_range(80));
      end
      8: begin
        return TSTATE_W'(TSTATE_MAX - $urandom_range(15));
      end
      default: begin
        return TSTATE_W'($urandom_range(TSTATE_MAX));
      end
    endcase
  endfunction

  task automatic send_random();
    logic                kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          hi;
    kind = $urandom_range(1) ? REQ_IO : REQ_MEM;
    if (kind == REQ_MEM) begin
      addr = ($urandom_range(9) < 6) ? ADDR_W'(MEM_LO + $urandom_range(16383))
                                     : ADDR_W'($urandom_range(65535));
    end else begin
      hi   = ($urandom_range(9) < 6) ? 8'(PORT_HI_LO + $urandom_range(63))
                                     : 8'($urandom_range(255));
      addr = {hi, 8'($urandom_range(255))};
    end
    send_request(kind, addr, pick_tstate());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: window edges of memory and ports, positions across
    // the fetch group, the first and last contended lines, the T-states just
    // past the contended area (no frame wrap), and I/O chains that start at
    // the top of the T-state field.
    send_request(REQ_MEM, 16'h0000, 17'd0);
    send_request(REQ_MEM, 16'h3FFF, TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_MEM, MEM_LO,   TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_MEM, MEM_HI,   TSTATE_W'(FIRST_CONTENDED + 1));
    send_request(REQ_MEM, 16'h8000, TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_MEM, MEM_LO,   TSTATE_W'(FIRST_CONTENDED - 1));
    send_request(REQ_MEM, MEM_LO,   TSTATE_W'(FIRST_CONTENDED + ACTIVE_LEN - 8));
    send_request(REQ_MEM, MEM_LO,   TSTATE_W'(FIRST_CONTENDED + ACTIVE_LEN - 1));
    send_request(REQ_MEM, MEM_LO,   TSTATE_W'(FIRST_CONTENDED + ACTIVE_LEN));
    send_request(REQ_MEM, MEM_HI,   TSTATE_W'(LAST_CONTENDED - LINE_LEN));
    send_request(REQ_MEM, MEM_HI,   TSTATE_W'(LAST_CONTENDED));
    send_request(REQ_MEM, 16'hFFFF, TSTATE_MAX);
    send_request(REQ_IO,  16'h00FE, TSTATE_W'(FIRST_CONTENDED - 1));
    send_request(REQ_IO,  16'h3FFE, TSTATE_W'(FIRST_CONTENDED + 3));
    send_request(REQ_IO,  16'h40FE, TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_IO,  16'h7F00, TSTATE_W'(FIRST_CONTENDED + 1));
    send_request(REQ_IO,  16'hFFFF, TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_IO,  16'h80FF, TSTATE_W'(FIRST_CONTENDED + 2));
    send_request(REQ_IO,  16'h4001, TSTATE_W'(FIRST_CONTENDED));
    send_request(REQ_IO,  16'h7FFF, TSTATE_W'(FIRST_CONTENDED + 5));
    send_request(REQ_IO,  16'h5555, TSTATE_W'(LAST_CONTENDED - LINE_LEN + ACTIVE_LEN - 3));
    send_request(REQ_IO,  16'h40FE, TSTATE_MAX);
    send_request(REQ_IO,  16'h0000, TSTATE_MAX);
    send_request(REQ_IO,  16'h7F01, TSTATE_MAX);
    send_request(REQ_IO,  16'hAAAB, TSTATE_W'(LAST_CONTENDED - 1));
    wait_drained();

    // Random traffic in three idling regimes, with a full drain in between.
    repeat (PHASE_ITEMS) send_random();
    wait_drained();
    send_idle_pct = 60;
    recv_idle_pct = 13;
    repeat (PHASE_ITEMS) send_random();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) send_random();
    wait_drained();

    if (timing_check.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
